// File: rtl/sitl_pkg.sv
// shared types and constants for the segment interval tile lookup
package sitl_pkg;

  localparam int PIECES = 1024;
  localparam int AW = $clog2(PIECES);
  localparam int CW = AW + 1;

  localparam int SEG_W = 16;
  localparam int POS_W = 32;
  localparam int TILE_W = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_REWIND = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV_RD,
    S_ADV_CHK,
    S_LAST_RD,
    S_LAST_CHK,
    S_POST,
    S_SCAN_RD,
    S_SCAN_CHK
  } state_t;

  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic [TILE_W-1:0] tile;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic finish;
    logic hit;
    logic set_exh;
    logic adv_inc;
    logic set_seg;
    logic set_last;
    logic j_first;
    logic j_inc;
  } ctl_t;

endpackage

// File: rtl/sitl_ram.sv
// generic single-write, single-read memory with registered read data
module sitl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sitl_ctrl.sv
// sequencer, bookmark state and compare logic of the tile lookup
module sitl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [sitl_pkg::SEG_W-1:0]    segment,
  input  logic [sitl_pkg::POS_W-1:0]    position,
  input  logic [sitl_pkg::POS_W-1:0]    end_position,
  input  logic [sitl_pkg::TILE_W-1:0]   tile,
  output logic                          done,
  output logic [sitl_pkg::TILE_W-1:0]   tile_index,
  output logic                          found,
  output sitl_pkg::ram_req_t            ram_req,
  input  sitl_pkg::entry_t              ram_rdata
);
  import sitl_pkg::*;

  state_t state, state_next;
  ctl_t ctl;

  logic [CW-1:0]     count;
  logic [CW-1:0]     first;
  logic [CW-1:0]     last;
  logic [CW-1:0]     j;
  logic [SEG_W-1:0]  cur_seg;
  logic              seg_valid;
  logic              exhausted;
  logic [SEG_W-1:0]  q_seg;
  logic [POS_W-1:0]  q_pos;

  logic          accept;
  kind_t         kind_in;
  logic [CW-1:0] j_inc;
  logic          contains;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign kind_in  = kind_t'(kind);
  assign j_inc    = j + CW'(1);
  assign contains = (ram_rdata.start_pos <= q_pos) && (q_pos <= ram_rdata.end_pos);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && kind_in == KIND_QUERY && !exhausted) begin
          if (!seg_valid || segment > cur_seg) begin
            state_next = S_ADV_RD;
          end else if (segment == cur_seg) begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_ADV_RD: begin
        state_next = (first >= count) ? S_IDLE : S_ADV_CHK;
      end
      S_ADV_CHK: begin
        state_next = (ram_rdata.seg < q_seg) ? S_ADV_RD : S_LAST_RD;
      end
      S_LAST_RD: begin
        state_next = (j_inc < count) ? S_LAST_CHK : S_POST;
      end
      S_LAST_CHK: begin
        state_next = (ram_rdata.seg == cur_seg) ? S_LAST_RD : S_POST;
      end
      S_POST: begin
        state_next = (cur_seg == q_seg) ? S_SCAN_RD : S_IDLE;
      end
      S_SCAN_RD: begin
        state_next = (j <= last) ? S_SCAN_CHK : S_IDLE;
      end
      S_SCAN_CHK: begin
        state_next = contains ? S_IDLE : S_SCAN_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    ram_req.we    = 1'b0;
    ram_req.waddr = count[AW-1:0];
    ram_req.wdata = '{seg: segment, start_pos: position, end_pos: end_position, tile: tile};
    ram_req.raddr = first[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept && kind_in == KIND_LOAD && count < CW'(PIECES)) begin
          ram_req.we = 1'b1;
        end
        if (accept && kind_in == KIND_QUERY) begin
          if (exhausted) begin
            ctl.finish = 1'b1;
          end else if (seg_valid && segment <= cur_seg) begin
            if (segment == cur_seg) begin
              ctl.j_first = 1'b1;
            end else begin
              ctl.finish = 1'b1;
            end
          end
        end
      end
      S_ADV_RD: begin
        if (first >= count) begin
          ctl.set_exh = 1'b1;
          ctl.finish  = 1'b1;
        end
      end
      S_ADV_CHK: begin
        if (ram_rdata.seg < q_seg) begin
          ctl.adv_inc = 1'b1;
        end else begin
          ctl.set_seg = 1'b1;
          ctl.j_first = 1'b1;
        end
      end
      S_LAST_RD: begin
        ram_req.raddr = j_inc[AW-1:0];
        if (!(j_inc < count)) begin
          ctl.set_last = 1'b1;
        end
      end
      S_LAST_CHK: begin
        if (ram_rdata.seg == cur_seg) begin
          ctl.j_inc = 1'b1;
        end else begin
          ctl.set_last = 1'b1;
        end
      end
      S_POST: begin
        if (cur_seg == q_seg) begin
          ctl.j_first = 1'b1;
        end else begin
          ctl.finish = 1'b1;
        end
      end
      S_SCAN_RD: begin
        ram_req.raddr = j[AW-1:0];
        if (!(j <= last)) begin
          ctl.finish = 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (contains) begin
          ctl.finish = 1'b1;
          ctl.hit    = 1'b1;
        end else begin
          ctl.j_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      first     <= '0;
      last      <= '0;
      cur_seg   <= '0;
      seg_valid <= 1'b0;
      exhausted <= 1'b0;
      done      <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.finish;
      found <= ctl.hit;
      if (accept && (kind_in == KIND_CLEAR || kind_in == KIND_REWIND)) begin
        first     <= '0;
        last      <= '0;
        cur_seg   <= '0;
        seg_valid <= 1'b0;
        exhausted <= 1'b0;
      end
      if (accept && kind_in == KIND_CLEAR) begin
        count <= '0;
      end
      if (ram_req.we) begin
        count <= count + CW'(1);
      end
      if (ctl.set_exh) begin
        exhausted <= 1'b1;
      end
      if (ctl.adv_inc) begin
        first <= first + CW'(1);
      end
      if (ctl.set_seg) begin
        cur_seg   <= ram_rdata.seg;
        seg_valid <= 1'b1;
      end
      if (ctl.set_last) begin
        last <= j;
      end
    end
  end

  // item latch, scan index and result data
  always_ff @(posedge clk) begin
    if (accept) begin
      q_seg <= segment;
      q_pos <= position;
    end
    if (ctl.j_first) begin
      j <= first;
    end else if (ctl.j_inc) begin
      j <= j_inc;
    end
    tile_index <= ctl.hit ? ram_rdata.tile : '0;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(PIECES))
    else $error("piece count above capacity");

  a_first_bound: assert property (@(posedge clk) disable iff (rst)
    first <= count)
    else $error("bookmark past piece count");

  a_busy_not_exh: assert property (@(posedge clk) disable iff (rst)
    busy |-> !exhausted)
    else $error("lookup running while exhausted");

  a_scan_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> (j <= last && j >= first))
    else $error("scan index outside run");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(busy) || $past(accept && kind_in == KIND_QUERY)))
    else $error("result without a query");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    found |-> done)
    else $error("found without result strobe");
`endif

endmodule

// File: rtl/segment_interval_tile_lookup.sv
// top level of the segment interval tile lookup
//
// Command channel: an item (kind, segment, position, end_position, tile) is
// taken at a rising edge with start high and busy low. Clear, load and rewind
// items finish in the cycle they are taken and never raise busy; a load past
// the table capacity is dropped. A query raises busy until its answer is out,
// unless the bookmark alone decides it. Result channel: done is high for
// exactly one cycle with tile_index and found; only queries give a result.
// The receiver cannot stall, so the result is simply presented for that one cycle.
// When the bookmark alone decides a query (exhausted, or segment behind the
// bookmark), done is set at the edge that takes the query. On the current
// segment the run is read piece by piece from its first piece until a piece
// contains the position (hit) or the run ends (miss). On a later segment the
// bookmark first skips the pieces of lower segments, then the end of the new
// run is found; a segment gap then answers a miss without a scan, and running
// off the table answers a miss and marks the bookmark exhausted.
// One memory with a single registered read port holds the table.
// A new item may be taken in the cycle done is high.
// Reset empties the table, clears the bookmark and leaves the block idle;
// table contents are not cleared, only the piece count.
module segment_interval_tile_lookup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [sitl_pkg::SEG_W-1:0]  segment,
  input  logic [sitl_pkg::POS_W-1:0]  position,
  input  logic [sitl_pkg::POS_W-1:0]  end_position,
  input  logic [sitl_pkg::TILE_W-1:0] tile,
  output logic                        done,
  output logic [sitl_pkg::TILE_W-1:0] tile_index,
  output logic                        found
);
  import sitl_pkg::*;

  ram_req_t         ram_req;
  logic [EW-1:0]    rdata_bits;
  entry_t           ram_rdata;

  assign ram_rdata = entry_t'(rdata_bits);

  sitl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .segment      (segment),
    .position     (position),
    .end_position (end_position),
    .tile         (tile),
    .done         (done),
    .tile_index   (tile_index),
    .found        (found),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  sitl_ram #(
    .WIDTH (EW),
    .DEPTH (PIECES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (EW'(ram_req.wdata)),
    .raddr (ram_req.raddr),
    .rdata (rdata_bits)
  );

endmodule

// File: dv/segment_interval_tile_lookup_checker.sv
// checker for the segment interval tile lookup: predicts and compares every answer
module segment_interval_tile_lookup_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [sitl_pkg::SEG_W-1:0]  segment,
  input  logic [sitl_pkg::POS_W-1:0]  position,
  input  logic [sitl_pkg::POS_W-1:0]  end_position,
  input  logic [sitl_pkg::TILE_W-1:0] tile,
  input  logic                        done,
  input  logic [sitl_pkg::TILE_W-1:0] tile_index,
  input  logic                        found,
  output int                          fail_count,
  output int                          pending
);
  import sitl_pkg::*;

  typedef struct packed {
    logic [TILE_W-1:0] tile_no;
    logic              hit;
  } answer_t;

  answer_t answers_due[$];

  logic [SEG_W-1:0]  tbl_seg   [PIECES];
  logic [POS_W-1:0]  tbl_start [PIECES];
  logic [POS_W-1:0]  tbl_end   [PIECES];
  logic [TILE_W-1:0] tbl_tile  [PIECES];

  int unsigned      n_pieces;
  int unsigned      run_first;
  int unsigned      run_last;
  logic [SEG_W-1:0] cur_seg;
  logic             have_seg;
  logic             past_end;
  answer_t          got;
  answer_t          want;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void restart_run();
    run_first = 0;
    run_last = 0;
    cur_seg = '0;
    have_seg = 1'b0;
    past_end = 1'b0;
  endfunction

  function automatic answer_t find_tile(logic [SEG_W-1:0] seg, logic [POS_W-1:0] pos);
    answer_t     a;
    int unsigned j;
    a = '0;
    if (past_end) return a;
    if (!have_seg || seg > cur_seg) begin
      while (run_first < n_pieces && tbl_seg[run_first] < seg) run_first++;
      if (run_first >= n_pieces) begin
        past_end = 1'b1;
        return a;
      end
      cur_seg = tbl_seg[run_first];
      have_seg = 1'b1;
      j = run_first;
      while (j + 1 < n_pieces && tbl_seg[j + 1] == cur_seg) j++;
      run_last = j;
    end
    if (cur_seg != seg) return a;
    for (j = run_first; j <= run_last && j < PIECES; j++) begin
      if (tbl_start[j] <= pos && pos <= tbl_end[j]) begin
        a.tile_no = tbl_tile[j];
        a.hit = 1'b1;
        return a;
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      n_pieces = 0;
      restart_run();
      answers_due.delete();
    end else begin
      if (done) begin
        got = '{tile_no: tile_index, hit: found};
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected answer: tile_index %h found %b", tile_index, found);
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected tile_index %h found %b, got tile_index %h found %b",
                       want.tile_no, want.hit, tile_index, found);
          end
        end
      end
      if (start && !busy) begin
        case (kind_t'(kind))
          KIND_CLEAR: begin
            n_pieces = 0;
            restart_run();
          end
          KIND_LOAD: begin
            if (n_pieces < PIECES) begin
              tbl_seg[n_pieces] = segment;
              tbl_start[n_pieces] = position;
              tbl_end[n_pieces] = end_position;
              tbl_tile[n_pieces] = tile;
              n_pieces++;
            end
          end
          KIND_QUERY: answers_due.push_back(find_tile(segment, position));
          default: restart_run();
        endcase
      end
    end
    pending = answers_due.size();
  end

endmodule

// File: dv/segment_interval_tile_lookup_tb.sv
// testbench top for the segment interval tile lookup: stimulus and verdict
module segment_interval_tile_lookup_tb;
  import sitl_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        kind = '0;
  logic [SEG_W-1:0]  segment = '0;
  logic [POS_W-1:0]  position = '0;
  logic [POS_W-1:0]  end_position = '0;
  logic [TILE_W-1:0] tile = '0;
  logic              busy;
  logic              done;
  logic [TILE_W-1:0] tile_index;
  logic              found;
  int                fail_count;
  int                pending;

  // mirror of the loaded table, used only to aim queries
  logic [SEG_W-1:0] plan_seg[$];
  logic [POS_W-1:0] plan_lo[$];
  logic [POS_W-1:0] plan_hi[$];
  int               cursor;
  int               sent;
  logic             quiet;

  initial forever #1 clk = ~clk;

  segment_interval_tile_lookup uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .segment(segment), .position(position), .end_position(end_position), .tile(tile),
    .done(done), .tile_index(tile_index), .found(found)
  );

  segment_interval_tile_lookup_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .segment(segment), .position(position), .end_position(end_position), .tile(tile),
    .done(done), .tile_index(tile_index), .found(found),
    .fail_count(fail_count), .pending(pending)
  );

  task automatic issue(input kind_t k, input logic [SEG_W-1:0] s, input logic [POS_W-1:0] p,
                       input logic [POS_W-1:0] e, input logic [TILE_W-1:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    segment <= s;
    position <= p;
    end_position <= e;
    tile <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic load_piece(input logic [SEG_W-1:0] s, input logic [POS_W-1:0] lo,
                            input logic [POS_W-1:0] hi, input logic [TILE_W-1:0] t);
    if (plan_seg.size() < PIECES) begin
      plan_seg.push_back(s);
      plan_lo.push_back(lo);
      plan_hi.push_back(hi);
    end
    issue(KIND_LOAD, s, lo, hi, t);
  endtask

  task automatic ask(input logic [SEG_W-1:0] s, input logic [POS_W-1:0] p);
    issue(KIND_QUERY, s, p, $urandom(), TILE_W'($urandom()));
  endtask

  task automatic wipe();
    plan_seg.delete();
    plan_lo.delete();
    plan_hi.delete();
    cursor = 0;
    issue(KIND_CLEAR, SEG_W'($urandom()), $urandom(), $urandom(), TILE_W'($urandom()));
  endtask

  task automatic restart_scan();
    cursor = 0;
    issue(KIND_REWIND, SEG_W'($urandom()), $urandom(), $urandom(), TILE_W'($urandom()));
  endtask

  function automatic logic [POS_W-1:0] near_pos(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      4: return (hi >= lo) ? lo + $urandom_range(0, hi - lo) : $urandom();
      default: return $urandom();
    endcase
  endfunction

  initial begin
    #100_000_000;
    $display("** segment_interval_tile_lookup: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int               n;
    int               stay;
    int               nq;
    int               r;
    int               step;
    logic             big_done;
    logic [SEG_W-1:0] sg;
    logic [SEG_W-1:0] s;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    big_done = 1'b0;
    quiet = 1'b0;
    sent = 0;
    cursor = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, then an unsorted table with extreme intervals and tiles
    ask(16'h0000, 32'h0000_0000);
    restart_scan();
    load_piece(16'h0000, 32'h0000_0000, 32'h8000_0000, 16'hFFFF);
    load_piece(16'h0000, 32'h4000_0000, 32'h5000_0000, 16'h0001);
    load_piece(16'h0005, 32'h0000_0010, 32'h0000_0020, 16'h0002);
    load_piece(16'h0005, 32'h0000_0030, 32'hFFFF_FFFF, 16'h0003);
    load_piece(16'h0003, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0004);
    load_piece(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
    ask(16'h0000, 32'h0000_0000);
    ask(16'h0000, 32'h8000_0000);
    ask(16'h0002, 32'h0000_0010);
    ask(16'h0001, 32'h0000_0010);
    ask(16'h0005, 32'hF000_0000);
    ask(16'h0005, 32'h0000_0025);
    ask(16'hFFFF, 32'hFFFF_FFFF);
    ask(16'hFFFF, 32'hFFFF_FFFE);
    restart_scan();
    ask(16'h0003, 32'h0000_0000);
    load_piece(16'hFFFF, 32'h0000_0000, 32'h0000_0010, 16'h0007);
    ask(16'hFFFF, 32'h0000_0005);
    // run past the end of the table, then come back
    wipe();
    load_piece(16'h0001, 32'h0000_0000, 32'h0000_0064, 16'h0009);
    ask(16'h0002, 32'h0000_0032);
    ask(16'h0001, 32'h0000_0032);
    restart_scan();
    ask(16'h0001, 32'h0000_0032);

    while (sent < 1950) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (plan_seg.size() == 0 || $urandom_range(0, 3) != 0) begin
        wipe();
        if (!big_done && sent > 500) begin
          // one full table with a few dropped loads
          n = PIECES + $urandom_range(1, 4);
          stay = $urandom_range(0, 1) ? 400 : 2;
          big_done = 1'b1;
        end else begin
          n = $urandom_range(0, 24);
          stay = $urandom_range(0, 4);
        end
        sg = SEG_W'($urandom_range(0, 16'hFFFF - 3 * n));
        for (int i = 0; i < n; i++) begin
          if (i > 0 && $urandom_range(0, stay) == 0) sg = SEG_W'(sg + $urandom_range(1, 3));
          s = ($urandom_range(0, 9) == 0) ? SEG_W'($urandom()) : sg;
          case ($urandom_range(0, 3))
            0: begin
              lo = $urandom_range(0, 32'h8000_0000);
              hi = lo + $urandom_range(0, 32'h8000_0000 - lo);
            end
            1: begin
              lo = $urandom();
              hi = $urandom();
            end
            2: begin
              lo = $urandom();
              hi = lo + $urandom_range(0, 255);
            end
            default: begin
              lo = '0;
              hi = 32'h8000_0000;
            end
          endcase
          load_piece(s, lo, hi, TILE_W'($urandom()));
        end
      end else begin
        restart_scan();
      end

      nq = $urandom_range(1, 30);
      for (int q = 0; q < nq; q++) begin
        r = $urandom_range(0, 19);
        if (plan_seg.size() == 0) begin
          ask(SEG_W'($urandom()), $urandom());
        end else if (r < 12) begin
          step = $urandom_range(0, 1) ? 0 : $urandom_range(1, 1 + plan_seg.size() / 16);
          cursor = cursor + step;
          if (cursor > plan_seg.size() - 1) cursor = plan_seg.size() - 1;
          ask(plan_seg[cursor], near_pos(plan_lo[cursor], plan_hi[cursor]));
        end else if (r < 14) begin
          ask(SEG_W'(plan_seg[cursor] + 1), near_pos(plan_lo[cursor], plan_hi[cursor]));
        end else if (r < 16) begin
          ask(SEG_W'(plan_seg[cursor] - 1), $urandom());
        end else if (r == 16) begin
          restart_scan();
        end else if (r == 17) begin
          load_piece(SEG_W'($urandom()), $urandom(), $urandom(), TILE_W'($urandom()));
        end else if (r == 18 || $urandom_range(0, 3) != 0) begin
          ask(SEG_W'($urandom()), $urandom());
        end else begin
          wipe();
        end
      end
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** segment_interval_tile_lookup: PASSED **");
    end else begin
      $display("** segment_interval_tile_lookup: FAILED **");
    end
    $finish;
  end

endmodule
